[src/tipq_pkg.sv]
// Package for the tagged instruction prefetch queue: depth, index widths,
// request codes and the request and response beat structs. No dependencies.
package tipq_pkg;

   localparam int QUEUE_DEPTH  = 4;
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);
   localparam int LVL_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_OUT_W  = 3;
   localparam int FETCH_STRIDE = 2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [LVL_W-1:0] lvl_type;

   typedef enum logic [1:0] {
      REQ_FILL    = 2'd0,
      REQ_CONSUME = 2'd1,
      REQ_FLUSH   = 2'd2,
      REQ_NOP     = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type req_type;
      logic [15:0]  bus_word;
      logic         bus_ok;
      logic [7:0]   fill_limit;
      logic [31:0]  restart_address;
   } req_beat_type;

   typedef struct packed {
      logic [15:0]            out_word;
      logic                   word_valid;
      logic [31:0]            peek_address;
      logic [31:0]            fetch_address;
      logic [LEVEL_OUT_W-1:0] level;
      logic [31:0]            consumed_total;
   } rsp_beat_type;

endpackage

[src/tagged_instruction_prefetch_queue_unit.sv]
// Top level of the tagged instruction prefetch queue: request register, queue
// update logic and response register. Depends on tipq_pkg.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | tipq_pkg::req_beat_type
//   rsp     | out       | rsp_valid/rsp_stall  | tipq_pkg::rsp_beat_type
//
// One beat in, one beat out, one beat per cycle sustained while rsp_stall is low.
// A request passes from the request register through the update logic into the
// response register; queue state changes on the same edge as the response loads.
// Synchronous reset empties the queue and clears head, level, fetch address
// and consumed count; stored words and tags are not reset.
// A stalled response holds the request register, which then stalls req.
module tagged_instruction_prefetch_queue_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tipq_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tipq_pkg::rsp_beat_type rsp_beat
);

   logic                   s1_valid_ff;
   tipq_pkg::req_beat_type s1_beat_ff;
   logic                   out_valid_ff, out_valid_in;
   tipq_pkg::rsp_beat_type out_beat_ff, out_beat_in;
   logic                   advance;

   logic [15:0]       word_store_ff [tipq_pkg::QUEUE_DEPTH];
   logic [31:0]       tag_store_ff  [tipq_pkg::QUEUE_DEPTH];
   tipq_pkg::idx_type head_ff, head_in;
   tipq_pkg::lvl_type level_ff, level_in;
   logic [31:0]       fetch_ff, fetch_in;
   logic [31:0]       consumed_ff, consumed_in;

   logic                      room;
   logic                      do_append;
   logic                      do_pop;
   logic [tipq_pkg::IDX_W:0]  tail_sum;
   tipq_pkg::idx_type         tail;
   tipq_pkg::idx_type         head_inc;
   tipq_pkg::lvl_type         level_app;
   logic [31:0]               fetch_app;
   logic [15:0]               word;
   logic [31:0]               peek;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   always_comb begin
      room = (8'(level_ff) < s1_beat_ff.fill_limit)
             && (level_ff < tipq_pkg::LVL_W'(tipq_pkg::QUEUE_DEPTH));

      tail_sum = (tipq_pkg::IDX_W+1)'(head_ff) + (tipq_pkg::IDX_W+1)'(level_ff);
      if (tail_sum >= (tipq_pkg::IDX_W+1)'(tipq_pkg::QUEUE_DEPTH)) begin
         tail = tipq_pkg::IDX_W'(tail_sum - (tipq_pkg::IDX_W+1)'(tipq_pkg::QUEUE_DEPTH));
      end else begin
         tail = tipq_pkg::IDX_W'(tail_sum);
      end

      if (head_ff == tipq_pkg::IDX_W'(tipq_pkg::QUEUE_DEPTH - 1)) begin
         head_inc = '0;
      end else begin
         head_inc = head_ff + tipq_pkg::IDX_W'(1);
      end

      do_append = 1'b0;
      unique case (s1_beat_ff.req_type)
         tipq_pkg::REQ_FILL:    do_append = s1_beat_ff.bus_ok && room;
         tipq_pkg::REQ_CONSUME: do_append = s1_beat_ff.bus_ok && (level_ff == '0);
         tipq_pkg::REQ_FLUSH:   do_append = 1'b0;
         tipq_pkg::REQ_NOP:     do_append = 1'b0;
         default:               do_append = 1'b0;
      endcase

      level_app = do_append ? level_ff + tipq_pkg::LVL_W'(1) : level_ff;
      fetch_app = do_append ? fetch_ff + 32'(tipq_pkg::FETCH_STRIDE) : fetch_ff;
      do_pop    = (s1_beat_ff.req_type == tipq_pkg::REQ_CONSUME) && (level_app != '0);

      if (!do_pop) begin
         word = '0;
      end else if (level_ff == '0) begin
         word = s1_beat_ff.bus_word;
      end else begin
         word = word_store_ff[head_ff];
      end

      head_in     = do_pop ? head_inc : head_ff;
      level_in    = do_pop ? level_app - tipq_pkg::LVL_W'(1) : level_app;
      fetch_in    = fetch_app;
      consumed_in = do_pop ? consumed_ff + 32'd1 : consumed_ff;

      if (s1_beat_ff.req_type == tipq_pkg::REQ_FLUSH) begin
         head_in  = '0;
         level_in = '0;
         fetch_in = s1_beat_ff.restart_address;
      end

      if (level_in == '0) begin
         peek = fetch_in;
      end else if (do_append && (tail == head_in)) begin
         peek = fetch_ff;
      end else begin
         peek = tag_store_ff[head_in];
      end

      out_beat_in.out_word       = word;
      out_beat_in.word_valid     = do_pop;
      out_beat_in.peek_address   = peek;
      out_beat_in.fetch_address  = fetch_in;
      out_beat_in.level          = tipq_pkg::LEVEL_OUT_W'(level_in);
      out_beat_in.consumed_total = consumed_in;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         head_ff      <= '0;
         level_ff     <= '0;
         fetch_ff     <= '0;
         consumed_ff  <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            head_ff     <= head_in;
            level_ff    <= level_in;
            fetch_ff    <= fetch_in;
            consumed_ff <= consumed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_beat_ff <= req_beat;
      end
      if (advance) begin
         out_beat_ff <= out_beat_in;
      end
      if (advance && do_append) begin
         word_store_ff[tail] <= s1_beat_ff.bus_word;
         tag_store_ff[tail]  <= fetch_ff;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= tipq_pkg::LVL_W'(tipq_pkg::QUEUE_DEPTH))
      else $error("queue level above depth");

   a_count_on_pop: assert property (@(posedge clock) disable iff (reset)
      advance && do_pop |=> consumed_ff == $past(consumed_ff) + 32'd1)
      else $error("consumed count did not advance on pop");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty request register");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_beat_ff.word_valid |-> out_beat_ff.out_word == 16'd0)
      else $error("word present without word_valid");

endmodule
